/* rtl/tq_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, operation and status codes, and controller/datapath buses
// for the team queue. No dependencies.
package tq_pkg;

    localparam int MEMBER_COUNT = 4096;
    localparam int MAX_TEAMS    = 16;
    localparam int QUEUE_DEPTH  = 256;

    localparam int CLASS_COUNT  = MAX_TEAMS + 1;
    localparam int NO_TEAM      = MAX_TEAMS;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int MEMBER_W = 12;
    localparam int TEAM_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int CLASS_W  = $clog2(CLASS_COUNT);
    localparam int USED_W   = $clog2(CLASS_COUNT + 1);
    localparam int TADDR_W  = $clog2(MEMBER_COUNT);

    localparam logic [OP_W-1:0] OP_ASSIGN  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // input transfer this cycle
        logic exec;     // execute captured operation
        logic sweep;    // write one table entry to no-team
        logic finish;   // post result of a clear on the last sweep entry
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic is_clear;
        logic sweep_last;
    } t_stat;

endpackage

/* rtl/tq_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/tq_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the team queue: idle / execute / table sweep.
// Depends on tq_pkg.
module tq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tq_pkg::t_stat i_stat,
    output tq_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_pending, n_pending;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;

    always_comb begin
        o_cmd.capture = o_in_ready && i_in_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.sweep   = (r_state == S_SWEEP);
        o_cmd.finish  = (r_state == S_SWEEP) && i_stat.sweep_last && r_pending;
    end

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_clear) begin
                    n_state   = S_SWEEP;
                    n_pending = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (i_stat.sweep_last) begin
                    n_state   = S_IDLE;
                    n_pending = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;  // table starts with a clearing pass
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
        end
    end

endmodule

/* rtl/tq_dp.sv */
`timescale 1ns / 1ps
// Team queue datapath: team table, slot store, links, free stack, per-class
// head/tail, class order ring and result register. Depends on tq_pkg, tq_ram.
module tq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tq_pkg::t_cmd                  i_cmd,
    output tq_pkg::t_stat                 o_stat,
    input  logic [tq_pkg::OP_W-1:0]       i_op,
    input  logic signed [tq_pkg::VALUE_W-1:0] i_element_value,
    input  logic [tq_pkg::MEMBER_W-1:0]   i_member_id,
    input  logic [tq_pkg::TEAM_W-1:0]     i_team_index,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [tq_pkg::VALUE_W-1:0] o_value_out,
    output logic [tq_pkg::STATUS_W-1:0]   o_status,
    output logic [tq_pkg::CNT_W-1:0]      o_occupancy
);

    // captured item
    logic [tq_pkg::OP_W-1:0]    r_op;
    logic [tq_pkg::VALUE_W-1:0] r_val;

    // control state
    logic [tq_pkg::TADDR_W-1:0] r_sweep_addr;
    logic [tq_pkg::CNT_W-1:0]   r_held, n_held;
    logic [tq_pkg::CNT_W-1:0]   r_sp, n_sp;       // returned slots on stack
    logic [tq_pkg::CNT_W-1:0]   r_fresh, n_fresh; // slots handed out fresh so far
    logic [tq_pkg::CLASS_COUNT-1:0] r_present;
    logic [tq_pkg::CLASS_W-1:0] r_first;
    logic [tq_pkg::USED_W-1:0]  r_used;

    // per-class ends and ring, payload only
    logic [tq_pkg::SLOT_W-1:0]  r_head [tq_pkg::CLASS_COUNT];
    logic [tq_pkg::SLOT_W-1:0]  r_tail [tq_pkg::CLASS_COUNT];
    logic [tq_pkg::CLASS_W-1:0] r_ring [tq_pkg::CLASS_COUNT];

    // result register
    logic                          r_out_valid;
    logic [tq_pkg::VALUE_W-1:0]    r_value_out;
    logic [tq_pkg::STATUS_W-1:0]   r_status;
    logic [tq_pkg::CNT_W-1:0]      r_occ;

    // RAM ports
    logic                          tbl_we;
    logic [tq_pkg::TADDR_W-1:0]    tbl_waddr;
    logic [tq_pkg::CLASS_W-1:0]    tbl_wdata, tbl_rd;
    logic [tq_pkg::VALUE_W-1:0]    val_rd;
    logic [tq_pkg::SLOT_W-1:0]     link_rd, stk_rd;

    logic                          in_range;
    logic [tq_pkg::CLASS_W-1:0]    enq_cls, front_cls, sel_cls;
    logic [tq_pkg::SLOT_W-1:0]     sel_head, sel_tail, slot;
    logic                          sel_present;
    logic                          enq_do, deq_do, deq_last;
    logic [tq_pkg::CLASS_W:0]      ring_sum;
    logic [tq_pkg::CLASS_W-1:0]    ring_wr, first_next;
    logic [tq_pkg::VALUE_W-1:0]    res_value;
    logic [tq_pkg::STATUS_W-1:0]   res_status;
    logic                          assign_ok;

    // class lookup
    assign in_range  = !r_val[tq_pkg::VALUE_W-1]
                     && (r_val < tq_pkg::VALUE_W'(tq_pkg::MEMBER_COUNT));
    assign enq_cls   = (in_range && (tbl_rd < tq_pkg::CLASS_W'(tq_pkg::CLASS_COUNT)))
                     ? tbl_rd : tq_pkg::CLASS_W'(tq_pkg::NO_TEAM);
    assign front_cls = r_ring[r_first];
    assign sel_cls   = (i_cmd.exec && (r_op == tq_pkg::OP_ENQUEUE)) ? enq_cls : front_cls;
    assign sel_head    = r_head[sel_cls];
    assign sel_tail    = r_tail[sel_cls];
    assign sel_present = r_present[sel_cls];

    assign slot = (r_sp != '0) ? stk_rd : r_fresh[tq_pkg::SLOT_W-1:0];

    assign ring_sum   = {1'b0, r_first} + (tq_pkg::CLASS_W + 1)'(r_used);
    assign ring_wr    = (ring_sum >= (tq_pkg::CLASS_W + 1)'(tq_pkg::CLASS_COUNT))
                      ? tq_pkg::CLASS_W'(ring_sum - (tq_pkg::CLASS_W + 1)'(tq_pkg::CLASS_COUNT))
                      : ring_sum[tq_pkg::CLASS_W-1:0];
    assign first_next = (r_first == tq_pkg::CLASS_W'(tq_pkg::CLASS_COUNT - 1))
                      ? '0 : r_first + tq_pkg::CLASS_W'(1);

    always_comb begin
        n_held     = r_held;
        n_sp       = r_sp;
        n_fresh    = r_fresh;
        res_value  = '1;
        res_status = tq_pkg::ST_OK;
        enq_do     = 1'b0;
        deq_do     = 1'b0;
        if (i_cmd.exec) begin
            case (r_op)
                tq_pkg::OP_ENQUEUE: begin
                    if (r_held == tq_pkg::CNT_W'(tq_pkg::QUEUE_DEPTH)) begin
                        res_status = tq_pkg::ST_FULL;
                    end else begin
                        enq_do = 1'b1;
                        n_held = r_held + tq_pkg::CNT_W'(1);
                        if (r_sp != '0) begin
                            n_sp = r_sp - tq_pkg::CNT_W'(1);
                        end else begin
                            n_fresh = r_fresh + tq_pkg::CNT_W'(1);
                        end
                    end
                end
                tq_pkg::OP_DEQUEUE: begin
                    if (r_held == '0) begin
                        res_status = tq_pkg::ST_EMPTY;
                    end else begin
                        deq_do    = 1'b1;
                        res_value = val_rd;
                        n_held    = r_held - tq_pkg::CNT_W'(1);
                        n_sp      = r_sp + tq_pkg::CNT_W'(1);
                    end
                end
                tq_pkg::OP_CLEAR: begin
                    n_held  = '0;
                    n_sp    = '0;
                    n_fresh = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign deq_last = (sel_head == sel_tail);

    // team table: sweep writes no-team, assign writes at capture
    assign assign_ok = (i_op == tq_pkg::OP_ASSIGN)
                     && (32'(i_member_id) < 32'(tq_pkg::MEMBER_COUNT))
                     && (32'(i_team_index) < 32'(tq_pkg::MAX_TEAMS));

    always_comb begin
        if (i_cmd.sweep) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_sweep_addr;
            tbl_wdata = tq_pkg::CLASS_W'(tq_pkg::NO_TEAM);
        end else begin
            tbl_we    = i_cmd.capture && assign_ok;
            tbl_waddr = tq_pkg::TADDR_W'(i_member_id);
            tbl_wdata = tq_pkg::CLASS_W'(i_team_index);
        end
    end

    tq_ram #(.WIDTH(tq_pkg::CLASS_W), .DEPTH(tq_pkg::MEMBER_COUNT)) u_team_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (tbl_waddr),
        .i_wr_data (tbl_wdata),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (i_element_value[tq_pkg::TADDR_W-1:0]),
        .o_rd_data (tbl_rd)
    );

    tq_ram #(.WIDTH(tq_pkg::VALUE_W), .DEPTH(tq_pkg::QUEUE_DEPTH)) u_value_store (
        .i_clk     (i_clk),
        .i_wr_en   (enq_do),
        .i_wr_addr (slot),
        .i_wr_data (r_val),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (sel_head),
        .o_rd_data (val_rd)
    );

    tq_ram #(.WIDTH(tq_pkg::SLOT_W), .DEPTH(tq_pkg::QUEUE_DEPTH)) u_next_link (
        .i_clk     (i_clk),
        .i_wr_en   (enq_do && sel_present),
        .i_wr_addr (sel_tail),
        .i_wr_data (slot),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (sel_head),
        .o_rd_data (link_rd)
    );

    tq_ram #(.WIDTH(tq_pkg::SLOT_W), .DEPTH(tq_pkg::QUEUE_DEPTH)) u_free_stack (
        .i_clk     (i_clk),
        .i_wr_en   (deq_do),
        .i_wr_addr (r_sp[tq_pkg::SLOT_W-1:0]),
        .i_wr_data (sel_head),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (r_sp[tq_pkg::SLOT_W-1:0] - tq_pkg::SLOT_W'(1)),
        .o_rd_data (stk_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_held       <= '0;
            r_sp         <= '0;
            r_fresh      <= '0;
            r_present    <= '0;
            r_first      <= '0;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep_addr <= o_stat.sweep_last ? '0
                              : r_sweep_addr + tq_pkg::TADDR_W'(1);
            end
            r_held  <= n_held;
            r_sp    <= n_sp;
            r_fresh <= n_fresh;
            if (enq_do && !sel_present) begin
                r_present[enq_cls] <= 1'b1;
                r_used             <= r_used + tq_pkg::USED_W'(1);
            end
            if (deq_do && deq_last) begin
                r_present[front_cls] <= 1'b0;
                r_first              <= first_next;
                r_used               <= r_used - tq_pkg::USED_W'(1);
            end
            if (i_cmd.exec && (r_op == tq_pkg::OP_CLEAR)) begin
                r_present <= '0;
                r_first   <= '0;
                r_used    <= '0;
            end
            if ((i_cmd.exec && (r_op != tq_pkg::OP_CLEAR)) || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_val <= i_element_value;
        end
        if (enq_do) begin
            r_tail[enq_cls] <= slot;
            if (!sel_present) begin
                r_head[enq_cls] <= slot;
                r_ring[ring_wr] <= enq_cls;
            end
        end
        if (deq_do && !deq_last) begin
            r_head[front_cls] <= link_rd;
        end
        if (i_cmd.exec || i_cmd.finish) begin
            r_value_out <= res_value;
            r_status    <= res_status;
            r_occ       <= n_held;
        end
    end

    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.is_clear   = (r_op == tq_pkg::OP_CLEAR);
    assign o_stat.sweep_last = (r_sweep_addr == tq_pkg::TADDR_W'(tq_pkg::MEMBER_COUNT - 1));

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_value_out;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

endmodule

/* rtl/team_queue_core.sv */
`timescale 1ns / 1ps
// Team queue top level: controller plus datapath.
// Depends on tq_pkg, tq_ctrl, tq_dp (and tq_ram through tq_dp).
//
// Usage
//   Input channel  (i_in_valid / o_in_ready): one operation per transfer:
//     assign member to team, enqueue value, dequeue, or clear.
//   Output channel (o_out_valid / i_out_ready): exactly one result per
//     operation, in order: dequeued value (-1 otherwise), status and the
//     number of values held after the operation.
//   Timing: one operation in flight at a time. An operation is taken
//     (registered reads of the team table, value store, link and free stack
//     RAMs) and executed in the following cycle, which loads the result
//     register; no new operation is taken before that result is registered.
//     A clear adds a sweep of the team table, one entry per cycle, over all
//     MEMBER_COUNT (4096) entries, and its result appears when the sweep ends.
//   Reset: after i_rst_n is released the team table is swept to no-team, all
//     4096 entries, with o_in_ready low; the queue itself is empty at once.
//   Stall: the result register holds while i_out_ready is low; a new
//     operation is taken only when that register is empty or being drained.
module team_queue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tq_pkg::OP_W-1:0]             i_op,
    input  logic signed [tq_pkg::VALUE_W-1:0]   i_element_value,
    input  logic [tq_pkg::MEMBER_W-1:0]         i_member_id,
    input  logic [tq_pkg::TEAM_W-1:0]           i_team_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tq_pkg::VALUE_W-1:0]   o_value_out,
    output logic [tq_pkg::STATUS_W-1:0]         o_status,
    output logic [tq_pkg::CNT_W-1:0]            o_occupancy
);

    tq_pkg::t_cmd  cmd;
    tq_pkg::t_stat stat;

    // sequencer: idle, execute, table sweep
    tq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // storage, linking and result register
    tq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_op),
        .i_element_value (i_element_value),
        .i_member_id     (i_member_id),
        .i_team_index    (i_team_index),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_value_out     (o_value_out),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

endmodule

/* rtl/tq_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the team queue, bound to team_queue_core.
// Depends on tq_pkg.
module tq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [tq_pkg::VALUE_W-1:0]  o_value_out,
    input logic [tq_pkg::STATUS_W-1:0]        o_status,
    input logic [tq_pkg::CNT_W-1:0]           o_occupancy
);

    // one operation in flight: no transfer in back-to-back cycles
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an operation is in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_value_out)
            && $stable(o_status) && $stable(o_occupancy)))
        else $error("result changed while stalled");

    // an empty dequeue reports -1 and zero occupancy
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == tq_pkg::ST_EMPTY)) |->
            ((o_value_out == -1) && (o_occupancy == '0)))
        else $error("bad empty dequeue result");

    // occupancy bounded; a dropped enqueue means the store is full
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_occupancy <= tq_pkg::CNT_W'(tq_pkg::QUEUE_DEPTH))
            && ((o_status != tq_pkg::ST_FULL)
                || (o_occupancy == tq_pkg::CNT_W'(tq_pkg::QUEUE_DEPTH)))))
        else $error("occupancy out of range");

endmodule

bind team_queue_core tq_checker u_tq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_value_out (o_value_out),
    .o_status    (o_status),
    .o_occupancy (o_occupancy)
);

/* tb/sv/tb_team_queue_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for team_queue_core: directed and random operations,
// checked against a behavioral team-queue predictor. Depends on tq_pkg and the RTL.
module tb_team_queue_core;

    typedef struct {
        logic [tq_pkg::OP_W-1:0]     op;
        logic [tq_pkg::VALUE_W-1:0]  value;
        logic [tq_pkg::MEMBER_W-1:0] member;
        logic [tq_pkg::TEAM_W-1:0]   team;
        int                  phase;      // idle profile while this item is offered
        bit                  drain_first; // offer only once no result is pending
        bit                  long_hold;  // receiver stops for a long stretch on transfer
    } t_op_item;

    typedef struct {
        logic [tq_pkg::VALUE_W-1:0]  value;
        logic [tq_pkg::STATUS_W-1:0] status;
        logic [tq_pkg::CNT_W-1:0]    occupancy;
    } t_result;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [tq_pkg::OP_W-1:0] i_op = tq_pkg::OP_ASSIGN;
    logic signed [tq_pkg::VALUE_W-1:0] i_element_value = '0;
    logic [tq_pkg::MEMBER_W-1:0] i_member_id = '0;
    logic [tq_pkg::TEAM_W-1:0] i_team_index = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [tq_pkg::VALUE_W-1:0] o_value_out;
    logic [tq_pkg::STATUS_W-1:0] o_status;
    logic [tq_pkg::CNT_W-1:0] o_occupancy;

    team_queue_core uut (.*);

    always #10 i_clk = ~i_clk;

    // Pending operations and expected results
    t_op_item pending_ops[$];
    t_result  expected_results[$];
    t_op_item cur_item;
    int       errors = 0;
    int       cycles = 0;
    int       cur_phase = 0;
    int       hold_left = 0;
    bit       hold_start = 1'b0;
    bit       in_taken = 1'b0;

    // Predictor state: member-to-team table, one FIFO per class, class order
    logic [tq_pkg::CLASS_W-1:0] team_of[tq_pkg::MEMBER_COUNT];
    int unsigned class_fifo[tq_pkg::CLASS_COUNT][$];
    int          class_order[$];
    int          held;

    function automatic void clear_model();
        foreach (team_of[i]) team_of[i] = tq_pkg::CLASS_W'(tq_pkg::NO_TEAM);
        foreach (class_fifo[c]) class_fifo[c].delete();
        class_order.delete();
        held = 0;
    endfunction

    function automatic t_result queue_step(t_op_item it);
        t_result r;
        int cls;
        r.value = '1;
        r.status = tq_pkg::ST_OK;
        case (it.op)
            tq_pkg::OP_ASSIGN: team_of[it.member] = tq_pkg::CLASS_W'(it.team);
            tq_pkg::OP_ENQUEUE: begin
                cls = tq_pkg::NO_TEAM;
                if (!it.value[tq_pkg::VALUE_W-1] && it.value < tq_pkg::MEMBER_COUNT)
                    cls = team_of[it.value[tq_pkg::MEMBER_W-1:0]];
                if (held >= tq_pkg::QUEUE_DEPTH) begin
                    r.status = tq_pkg::ST_FULL;
                end else begin
                    held++;
                    if (class_fifo[cls].size() == 0) class_order.push_back(cls);
                    class_fifo[cls].push_back(it.value);
                end
            end
            tq_pkg::OP_DEQUEUE: begin
                if (held == 0) begin
                    r.status = tq_pkg::ST_EMPTY;
                end else begin
                    cls = class_order[0];
                    r.value = class_fifo[cls].pop_front();
                    held--;
                    if (class_fifo[cls].size() == 0) void'(class_order.pop_front());
                end
            end
            default: clear_model();
        endcase
        r.occupancy = tq_pkg::CNT_W'(held);
        return r;
    endfunction

    // Transfers on both channels; predict on input, check on output
    always @(posedge i_clk) begin
        t_result e;
        cycles <= cycles + 1;
        in_taken = 1'b0;
        hold_start = 1'b0;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: value %0d", o_value_out);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_value_out !== e.value) begin
                    $error("value_out expected %0d actual %0d", $signed(e.value), o_value_out);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_occupancy !== e.occupancy) begin
                    $error("occupancy expected %0d actual %0d", e.occupancy, o_occupancy);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            in_taken = 1'b1;
            expected_results.push_back(queue_step(cur_item));
            cur_phase = cur_item.phase;
            if (cur_item.long_hold) hold_start = 1'b1;
        end
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int send_idle_pct(int ph);
        return (ph == 1) ? 48 : (ph == 3) ? 27 : 0;
    endfunction

    function automatic int recv_stall_pct(int ph);
        return (ph == 2) ? 48 : (ph == 3) ? 27 : 0;
    endfunction

    // Driver: holds the offered item until transfer, then picks the next one
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (pending_ops.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (chance(send_idle_pct(pending_ops[0].phase)) ||
                         (pending_ops[0].drain_first && expected_results.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                cur_item = pending_ops.pop_front();
                i_in_valid <= 1'b1;
                i_op <= cur_item.op;
                i_element_value <= cur_item.value;
                i_member_id <= cur_item.member;
                i_team_index <= cur_item.team;
            end
        end
    end

    // Receiver: long hold when requested, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_left <= LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n && !chance(recv_stall_pct(cur_phase));
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("team_queue_core: mismatch");
            $finish;
        end
    end

    task automatic add_op(logic [tq_pkg::OP_W-1:0] op, logic [tq_pkg::VALUE_W-1:0] v,
                          logic [tq_pkg::MEMBER_W-1:0] m, logic [tq_pkg::TEAM_W-1:0] t,
                          int ph = 0, bit drain = 1'b0, bit hold = 1'b0);
        t_op_item it;
        it.op = op;
        it.value = v;
        it.member = m;
        it.team = t;
        it.phase = ph;
        it.drain_first = drain;
        it.long_hold = hold;
        pending_ops.push_back(it);
    endtask

    function automatic logic [tq_pkg::VALUE_W-1:0] rand_value();
        int k;
        k = $urandom_range(9);
        if (k < 6) return $urandom_range(31);
        if (k < 7) return $urandom_range(tq_pkg::MEMBER_COUNT - 1, tq_pkg::MEMBER_COUNT - 32);
        return $urandom;
    endfunction

    function automatic logic [tq_pkg::MEMBER_W-1:0] rand_member();
        int k;
        k = $urandom_range(9);
        if (k < 6) return tq_pkg::MEMBER_W'($urandom_range(31));
        if (k < 8)
            return tq_pkg::MEMBER_W'($urandom_range(tq_pkg::MEMBER_COUNT - 1,
                                                    tq_pkg::MEMBER_COUNT - 32));
        return tq_pkg::MEMBER_W'($urandom);
    endfunction

    initial begin
        int k;
        clear_model();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: team extremes, odd values, reassign while queued, clear
        add_op(tq_pkg::OP_DEQUEUE, 0, 0, 0);
        add_op(tq_pkg::OP_ASSIGN, 0, 12'd5, 4'd3);
        add_op(tq_pkg::OP_ASSIGN, 0, 12'd0, 4'd0);
        add_op(tq_pkg::OP_ASSIGN, 0, 12'hFFF, 4'd15);
        add_op(tq_pkg::OP_ENQUEUE, 32'd5, 0, 0);
        add_op(tq_pkg::OP_ENQUEUE, 32'd7, 0, 0);
        add_op(tq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 0, 0);
        add_op(tq_pkg::OP_ENQUEUE, 32'h7FFF_FFFF, 0, 0);
        add_op(tq_pkg::OP_ENQUEUE, 32'h8000_0000, 0, 0);
        add_op(tq_pkg::OP_ENQUEUE, 32'd4096, 0, 0);
        add_op(tq_pkg::OP_ENQUEUE, 32'd5, 0, 0);
        add_op(tq_pkg::OP_ENQUEUE, 32'd4095, 0, 0);
        add_op(tq_pkg::OP_ENQUEUE, 32'd0, 0, 0);
        add_op(tq_pkg::OP_ASSIGN, 0, 12'd5, 4'd9);
        add_op(tq_pkg::OP_ENQUEUE, 32'd5, 0, 0);
        for (k = 0; k < 5; k++) add_op(tq_pkg::OP_DEQUEUE, 0, 0, 0);
        add_op(tq_pkg::OP_CLEAR, 32'hFFFF_FFFF, 12'hFFF, 4'hF);
        add_op(tq_pkg::OP_ENQUEUE, 32'd5, 0, 0);
        add_op(tq_pkg::OP_DEQUEUE, 0, 0, 0);
        add_op(tq_pkg::OP_DEQUEUE, 0, 0, 0);

        // Fill past full with the receiver held off, then drain past empty
        for (k = 0; k < 16; k++)
            add_op(tq_pkg::OP_ASSIGN, 0, tq_pkg::MEMBER_W'(k), tq_pkg::TEAM_W'($urandom),
                   0, k == 0);
        for (k = 0; k < 265; k++)
            add_op(tq_pkg::OP_ENQUEUE, rand_value(), 0, 0, k / 70, 1'b0, k == 0);
        for (k = 0; k < 262; k++)
            add_op(tq_pkg::OP_DEQUEUE, 0, 0, 0, 3 - k / 70, k == 0);

        // Random mix, cycling through the idle profiles
        for (k = 0; k < 360; k++) begin
            int r;
            r = $urandom_range(99);
            if (r < 25)
                add_op(tq_pkg::OP_ASSIGN, $urandom, rand_member(),
                       tq_pkg::TEAM_W'($urandom), (k / 45) % 4);
            else if (r < 65)
                add_op(tq_pkg::OP_ENQUEUE, rand_value(), tq_pkg::MEMBER_W'($urandom),
                       tq_pkg::TEAM_W'($urandom), (k / 45) % 4);
            else if (r < 99)
                add_op(tq_pkg::OP_DEQUEUE, $urandom, tq_pkg::MEMBER_W'($urandom),
                       tq_pkg::TEAM_W'($urandom), (k / 45) % 4, r == 98);
            else
                add_op(tq_pkg::OP_CLEAR, $urandom, tq_pkg::MEMBER_W'($urandom),
                       tq_pkg::TEAM_W'($urandom), (k / 45) % 4);
        end

        // sample settled state at the rising edge until all work is done
        do
            @(posedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("team_queue_core: match");
        else
            $display("team_queue_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tq_pkg.sv
rtl/tq_ram.sv
rtl/tq_ctrl.sv
rtl/tq_dp.sv
rtl/team_queue_core.sv
rtl/tq_checker.sv
tb/sv/tb_team_queue_core.sv
